[src/assert_macros.svh]
// Assertion macros used by the RTL file pcr_bank_sha256_extend.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop) label: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("assertion failed");
`define ASSERT_NEVER(label, expr) label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
  else $error("assertion failed");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

[src/pcrx_pkg.sv]
// Package for the measurement bank: command and status codes, SHA-256 constants.
// No dependencies.
package pcrx_pkg;
  localparam int NumRegsDefault = 24;
  localparam logic [1:0] CMD_EXTEND  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESET   = 2'd2;
  localparam logic [1:0] CMD_RESTORE = 2'd3;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_IDX  = 2'd1;
  localparam logic [1:0] ST_NO_RESET = 2'd2;

  typedef struct packed {
    logic start;
    logic second;
  } core_ctl_t;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
endpackage

[src/pcrx_sha_core.sv]
// SHA-256 compression unit: one round per cycle, two blocks for a 64-byte message.
// Depends on pcrx_pkg.
module pcrx_sha_core (
  input  logic                clk,
  input  logic                rst,
  input  pcrx_pkg::core_ctl_t ctl,
  input  logic [511:0]        blk,
  output logic                done,
  output logic [255:0]        digest
);
  logic [255:0] h;
  logic [255:0] v;
  logic [511:0] w;
  logic [5:0]   rnd;
  logic         busy;
  logic [31:0]  a, b, c, d, e, f, g, hh;
  logic [31:0]  w0, w1, w9, w14, s0, s1, wn, t1, t2;
  logic [255:0] v_next;
  logic [255:0] h_sum;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign {a, b, c, d, e, f, g, hh} = v;
  assign w0  = w[511:480];
  assign w1  = w[479:448];
  assign w9  = w[223:192];
  assign w14 = w[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wn  = w0 + s0 + w9 + s1;
  assign t1  = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + pcrx_pkg::sha_k(rnd) + w0;
  assign t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign v_next = {t1 + t2, a, b, c, d + t1, e, f, g};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_sum[32*i +: 32] = h[32*i +: 32] + v_next[32*i +: 32];
    end
  end

  assign digest = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      rnd    <= '0;
    end else begin
      done <= !ctl.start && busy && (rnd == 6'd63);
      if (ctl.start) begin
        busy   <= 1'b1;
        rnd    <= '0;
        w      <= blk;
        v      <= ctl.second ? h : pcrx_pkg::SHA_IV;
        if (!ctl.second) h <= pcrx_pkg::SHA_IV;
      end else if (busy) begin
        v   <= v_next;
        w   <= {w[479:0], wn};
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          h    <= h_sum;
        end
      end
    end
  end
endmodule

[src/pcr_bank_sha256_extend.sv]
// Bank of measurement registers extended with SHA-256. Each command is four word
// requests; the one with word_pos 3 fires it, whatever order the words come in. Extend
// runs the one-round-per-cycle compression unit over two blocks; read, reset and
// restore answer without it. Not ready while a command runs.
// Depends on pcrx_pkg, pcrx_sha_core and assert_macros.svh.
`include "assert_macros.svh"
module pcr_bank_sha256_extend #(
  parameter int NUM_REGS = pcrx_pkg::NumRegsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // command[1:0], pcr_index[9:2], data_word[73:10],
                                 // word_pos[75:74], zero fill
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // status[1:0], read_word[65:2], read_pos[67:66], zero fill
  output logic        m_tlast
);
  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_HASH1 = 3'd2,
                         S_HASH2 = 3'd3, S_OUT = 3'd4;

  logic [255:0] store [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [63:0]  staging [4];
  logic [4:0]   first_resettable;
  logic [2:0]   state;
  logic [1:0]   cmd;
  logic [7:0]   idx;
  logic [IW-1:0] ridx;
  logic [255:0] rdata;
  logic [1:0]   status;
  logic [1:0]   opos;
  logic         many;
  logic         launched;
  logic         core_done;
  logic [255:0] core_digest;
  pcrx_pkg::core_ctl_t ctl;
  logic [511:0] blk;
  logic [1:0]   in_cmd, in_pos;
  logic [7:0]   in_idx;
  logic [63:0]  in_word;
  logic         in_ok;
  logic [255:0] staged;

  assign in_cmd  = s_tdata[1:0];
  assign in_idx  = s_tdata[9:2];
  assign in_word = s_tdata[73:10];
  assign in_pos  = s_tdata[75:74];
  assign in_ok   = {24'd0, in_idx} < 32'(NUM_REGS);
  assign staged  = {staging[0], staging[1], staging[2], staging[3]};
  assign s_tready = (state == S_IDLE);

  assign blk = (state == S_HASH1) ? {rdata, staged}
                                  : {32'h80000000, 448'd0, 32'd512};
  assign ctl.start  = ((state == S_HASH1) || (state == S_HASH2)) && !launched;
  assign ctl.second = (state == S_HASH2);

  pcrx_sha_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .blk(blk), .done(core_done), .digest(core_digest)
  );

  always_ff @(posedge clk) begin
    rdata <= valid[ridx] ? store[ridx] : 256'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      first_resettable <= 5'd16;
      m_tvalid <= 1'b0;
      launched <= 1'b0;
    end else begin
      if (cfg_we) first_resettable <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            staging[in_pos] <= in_word;
            if (in_pos == 2'd3) begin
              cmd  <= in_cmd;
              idx  <= in_idx;
              ridx <= in_ok ? in_idx[IW-1:0] : '0;
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          opos <= 2'd0;
          if ({24'd0, idx} >= 32'(NUM_REGS)) begin
            many <= 1'b0;
            status <= (cmd == pcrx_pkg::CMD_RESTORE) ? pcrx_pkg::ST_OK
                                                     : pcrx_pkg::ST_BAD_IDX;
            state <= S_OUT;
            m_tvalid <= 1'b1;
          end else begin
            case (cmd)
              pcrx_pkg::CMD_EXTEND: begin
                many <= 1'b0;
                status <= pcrx_pkg::ST_OK;
                state <= S_HASH1;
                launched <= 1'b0;
              end
              pcrx_pkg::CMD_READ: begin
                many <= 1'b1;
                status <= pcrx_pkg::ST_OK;
                state <= S_OUT;
                m_tvalid <= 1'b1;
              end
              pcrx_pkg::CMD_RESET: begin
                many <= 1'b0;
                state <= S_OUT;
                m_tvalid <= 1'b1;
                if (idx < {3'd0, first_resettable}) status <= pcrx_pkg::ST_NO_RESET;
                else begin
                  status <= pcrx_pkg::ST_OK;
                  store[ridx] <= 256'd0;
                  valid[ridx] <= 1'b1;
                end
              end
              default: begin
                many <= 1'b0;
                status <= pcrx_pkg::ST_OK;
                state <= S_OUT;
                m_tvalid <= 1'b1;
                store[ridx] <= staged;
                valid[ridx] <= 1'b1;
              end
            endcase
          end
        end
        S_HASH1: begin
          launched <= !core_done;
          if (core_done) state <= S_HASH2;
        end
        S_HASH2: begin
          launched <= 1'b1;
          if (core_done) begin
            store[ridx] <= core_digest;
            valid[ridx] <= 1'b1;
            state <= S_OUT;
            m_tvalid <= 1'b1;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (!many || opos == 2'd3) begin
              m_tvalid <= 1'b0;
              state <= S_IDLE;
            end else opos <= opos + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [63:0] oword;
  always_comb begin
    case (opos)
      2'd0: oword = rdata[255:192];
      2'd1: oword = rdata[191:128];
      2'd2: oword = rdata[127:64];
      default: oword = rdata[63:0];
    endcase
  end

  assign m_tdata = {4'd0, many ? opos : 2'd0, many ? oword : 64'd0, status};
  assign m_tlast = !many || (opos == 2'd3);

  `ASSERT_NEVER(a_ready_out, s_tready && m_tvalid)
  `ASSERT_IMPL(a_done_in_hash, core_done |-> (state == S_HASH1 || state == S_HASH2))
  `ASSERT_IMPL(a_read_ok, (m_tvalid && many) |-> (status == pcrx_pkg::ST_OK))
endmodule

[tb/pcr_bank_checker.sv]
// Checker for the SHA-256 measurement bank: watches both streams, keeps its own copy of
// the bank, computes the expected response words and compares them field by field.
// Depends on pcrx_pkg.
`timescale 1ns / 1ps
module pcr_bank_checker #(
  parameter int NUM_REGS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] word;
    logic [1:0]  pos;
    logic        last;
  } resp_t;

  logic [255:0] bank [NUM_REGS];
  logic [63:0]  staged [4];
  logic [4:0]   reset_floor;
  resp_t        resp_q [$];

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_block(logic [255:0] h_in, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    logic [255:0] h_out;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = h_in[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_out[255 - 32*i -: 32] = h_in[255 - 32*i -: 32] + v[i];
    return h_out;
  endfunction

  function automatic logic [255:0] extend_digest(logic [255:0] old_val, logic [255:0] add);
    logic [255:0] h;
    h = sha_block(pcrx_pkg::SHA_IV, {old_val, add});
    return sha_block(h, {32'h80000000, 448'd0, 32'd512});
  endfunction

  task automatic push_status(logic [1:0] st);
    resp_t r;
    r = '{status: st, word: 64'd0, pos: 2'd0, last: 1'b1};
    resp_q.push_back(r);
  endtask

  task automatic apply_request(logic [79:0] d);
    logic [1:0] cmd;
    logic [7:0] idx;
    logic [1:0] wpos;
    logic [255:0] val;
    resp_t r;
    cmd = d[1:0];
    idx = d[9:2];
    wpos = d[75:74];
    staged[wpos] = d[73:10];
    if (wpos != 2'd3) return;
    val = {staged[0], staged[1], staged[2], staged[3]};
    if (idx >= NUM_REGS) begin
      push_status(cmd == pcrx_pkg::CMD_RESTORE ? pcrx_pkg::ST_OK : pcrx_pkg::ST_BAD_IDX);
      return;
    end
    case (cmd)
      pcrx_pkg::CMD_EXTEND: begin
        bank[idx] = extend_digest(bank[idx], val);
        push_status(pcrx_pkg::ST_OK);
      end
      pcrx_pkg::CMD_READ: begin
        for (int k = 0; k < 4; k++) begin
          r = '{status: pcrx_pkg::ST_OK, word: bank[idx][255 - 64*k -: 64], pos: k[1:0],
                last: (k == 3)};
          resp_q.push_back(r);
        end
      end
      pcrx_pkg::CMD_RESET: begin
        if (idx < reset_floor) push_status(pcrx_pkg::ST_NO_RESET);
        else begin
          bank[idx] = '0;
          push_status(pcrx_pkg::ST_OK);
        end
      end
      default: begin
        bank[idx] = val;
        push_status(pcrx_pkg::ST_OK);
      end
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = resp_q.size();

  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) bank[i] = '0;
      for (int i = 0; i < 4; i++) staged[i] = '0;
      reset_floor = 5'd16;
      resp_q.delete();
    end else begin
      if (cfg_we) reset_floor = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (resp_q.size() == 0) report("unexpected response", m_tdata[65:2], 64'd0);
        else begin
          e = resp_q.pop_front();
          if (m_tdata[1:0] !== e.status) report("status", m_tdata[1:0], e.status);
          if (m_tdata[65:2] !== e.word) report("read_word", m_tdata[65:2], e.word);
          if (m_tdata[67:66] !== e.pos) report("read_pos", m_tdata[67:66], e.pos);
          if (m_tlast !== e.last) report("last", m_tlast, e.last);
          if (m_tdata[71:68] !== 4'd0) report("fill", m_tdata[71:68], 64'd0);
        end
      end
      if (s_tvalid && s_tready) apply_request(s_tdata);
    end
  end
endmodule

[tb/testbench.sv]
// Top of the measurement bank regression: clock, reset, request stimulus, configuration
// phases and the verdict. Depends on pcrx_pkg, pcr_bank_sha256_extend and pcr_bank_checker.
`timescale 1ns / 1ps
module testbench;
  localparam int NUM_REGS = 24;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          idle_pct = 37;
  bit          hold_off = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pcr_bank_sha256_extend #(.NUM_REGS(NUM_REGS)) u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .cfg_we, .cfg_wdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast);

  pcr_bank_checker #(.NUM_REGS(NUM_REGS)) u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .cfg_we, .cfg_wdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .fail_count, .pending);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pcr_bank_sha256_extend regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_word(logic [1:0] cmd, logic [7:0] idx, logic [63:0] w, logic [1:0] wpos);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {4'd0, wpos, w, idx, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [7:0] idx, logic [255:0] v);
    for (int k = 0; k < 4; k++) send_word(cmd, idx, v[255 - 64*k -: 64], k[1:0]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [7:0] rand_index();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, NUM_REGS));
    return 8'($urandom_range(NUM_REGS - 1));
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_floor(logic [4:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_cmd();
    logic [1:0] cmd;
    logic [7:0] idx;
    int order;
    cmd = 2'($urandom_range(3));
    idx = rand_index();
    order = $urandom_range(9);
    if (order == 0) begin
      send_word(2'($urandom_range(3)), 8'($urandom()), rand64(), 2'($urandom_range(2)));
      send_word(cmd, idx, rand64(), 2'd3);
    end else if (order == 1) begin
      for (int k = 3; k >= 0; k--) send_word(cmd, idx, rand64(), k[1:0]);
    end else begin
      send_cmd(cmd, idx, {rand64(), rand64(), rand64(), rand64()});
    end
  endtask

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_cmd(pcrx_pkg::CMD_READ, 8'd0, {4{64'hffffffffffffffff}});
    send_cmd(pcrx_pkg::CMD_EXTEND, 8'd0, {4{64'hffffffffffffffff}});
    send_cmd(pcrx_pkg::CMD_READ, 8'd0, '0);
    send_cmd(pcrx_pkg::CMD_RESTORE, 8'd23, {64'h0123456789abcdef, 64'h0,
                                            64'hffffffffffffffff, 64'h8000000000000001});
    send_cmd(pcrx_pkg::CMD_READ, 8'd23, '0);
    send_cmd(pcrx_pkg::CMD_RESET, 8'd15, '0);
    send_cmd(pcrx_pkg::CMD_RESET, 8'd23, '0);
    send_cmd(pcrx_pkg::CMD_EXTEND, 8'd24, '0);
    send_cmd(pcrx_pkg::CMD_READ, 8'd255, '0);
    send_cmd(pcrx_pkg::CMD_RESET, 8'd200, '0);
    send_cmd(pcrx_pkg::CMD_RESTORE, 8'd24, {4{64'h5555555555555555}});

    write_floor(5'd0);
    send_cmd(pcrx_pkg::CMD_RESET, 8'd0, '0);
    write_floor(5'd24);
    send_cmd(pcrx_pkg::CMD_RESET, 8'd23, '0);
    write_floor(5'd31);

    sent = 0;
    while (sent < 120) begin
      random_cmd();
      sent += 4;
    end
    write_floor(5'($urandom_range(23, 1)));

    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_cmd(pcrx_pkg::CMD_READ, 8'($urandom_range(23)), '0);
    join
    drain();

    idle_pct = 0;
    while (sent < 200) begin
      random_cmd();
      sent += 4;
    end
    idle_pct = 37;
    write_floor(5'd16);
    while (sent < 310) begin
      random_cmd();
      sent += 4;
    end

    drain();
    if (fail_count == 0) $display("pcr_bank_sha256_extend regression: pass");
    else $display("pcr_bank_sha256_extend regression: fail");
    $finish;
  end
endmodule
